// File: sv/cpos_pkg.sv
// ----------------------------------------------------------------------------
// cpos_pkg
// Shared types, constants, the residue encoder and the joint cell address
// function for the column pair covariance score block.
// ----------------------------------------------------------------------------
package cpos_pkg;

    localparam int NUM_SYMBOLS = 21;
    localparam int SYM_W       = 5;
    localparam int CNT_W       = 9;
    localparam int PAIR_DEPTH  = NUM_SYMBOLS * NUM_SYMBOLS;
    localparam int PAIR_AW     = 9;
    localparam int SCORE_W     = 40;
    localparam int FRAC_W      = 16;
    localparam int NUM_W       = 33;
    localparam int QUO_W       = NUM_W + FRAC_W;
    localparam int DEN_W       = 25;
    localparam int OP_W        = 17;
    localparam int ITER_W      = 6;

    localparam logic [SYM_W-1:0]   NO_SYMBOL = 5'd21;
    localparam logic [SYM_W-1:0]   LAST_SYM  = 5'd20;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_COL = 1'b1;

    localparam logic REG_NUM_SEQS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_PAIR,
        ST_CNT_WR,
        ST_SC_RD,
        ST_SC_CHK,
        ST_SC_M1,
        ST_SC_M2,
        ST_SC_M3,
        ST_SC_M4,
        ST_SC_DS,
        ST_SC_DIV,
        ST_SC_ADD,
        ST_SC_NEXT,
        ST_DONE
    } state_t;

    // Map a raw residue byte to its symbol code
    function automatic logic [SYM_W-1:0] encode_byte(input logic [7:0] b);
        logic [SYM_W-1:0] s;
        case (b)
            8'h2D:   s = 5'd0;   // gap
            8'h41:   s = 5'd1;   // A
            8'h43:   s = 5'd2;   // C
            8'h44:   s = 5'd3;   // D
            8'h45:   s = 5'd4;   // E
            8'h46:   s = 5'd5;   // F
            8'h47:   s = 5'd6;   // G
            8'h48:   s = 5'd7;   // H
            8'h49:   s = 5'd8;   // I
            8'h4B:   s = 5'd9;   // K
            8'h4C:   s = 5'd10;  // L
            8'h4D:   s = 5'd11;  // M
            8'h4E:   s = 5'd12;  // N
            8'h50:   s = 5'd13;  // P
            8'h51:   s = 5'd14;  // Q
            8'h52:   s = 5'd15;  // R
            8'h53:   s = 5'd16;  // S
            8'h54:   s = 5'd17;  // T
            8'h56:   s = 5'd18;  // V
            8'h57:   s = 5'd19;  // W
            8'h59:   s = 5'd20;  // Y
            default: s = NO_SYMBOL;
        endcase
        return s;
    endfunction

    // Joint count cell address
    function automatic logic [PAIR_AW-1:0] pair_addr(input logic [SYM_W-1:0] x,
                                                     input logic [SYM_W-1:0] y);
        return PAIR_AW'(x) * PAIR_AW'(NUM_SYMBOLS) + PAIR_AW'(y);
    endfunction

endpackage

// File: sv/cpos_divider.sv
// ----------------------------------------------------------------------------
// cpos_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpos_divider
    import cpos_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= ITER_W'(QUO_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/column_pair_omes_score.sv
// ----------------------------------------------------------------------------
// column_pair_omes_score
// OMES covariance score of two alignment columns over a loaded alignment.
// ----------------------------------------------------------------------------
// Load: stores one residue, no result. Query: per row a read, a pair step and,
// for a pair of two symbols, a count write; then per joint cell a read and a
// check, and for a filled cell four products on one shared multiplier, then a
// 49-step divide and the add; bad-column and same-column queries strobe the next cycle.
// After reset a pass clears all 441 joint count cells; busy stays high.
// Results are strobed on done for one cycle; the receiver cannot stall.
module column_pair_omes_score
    import cpos_pkg::*;
#(
    parameter int MAX_SEQS = 256,
    parameter int MAX_COLS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [7:0]         seq_index,
    input  logic [7:0]         col_a,
    input  logic [7:0]         col_b,
    input  logic [7:0]         residue,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [CNT_W-1:0]   wr_data,
    output logic               done,
    output logic [SCORE_W-1:0] score,
    output logic               status
);

    localparam int STORE_DEPTH = MAX_SEQS * MAX_COLS;
    localparam int AW          = $clog2(STORE_DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   num_seqs_reg;
    logic [CNT_W-1:0]   num_cols_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   l_eff;

    logic [SYM_W-1:0]   store_mem [STORE_DEPTH];
    logic [SYM_W-1:0]   sym_a_reg;
    logic [SYM_W-1:0]   sym_b_reg;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [AW-1:0]      ld_addr;
    logic               ld_en;

    logic [CNT_W-1:0]   pair_mem [PAIR_DEPTH];
    logic [CNT_W-1:0]   pair_q_reg;
    logic [PAIR_AW-1:0] pair_raddr;
    logic [PAIR_AW-1:0] pair_waddr;
    logic [CNT_W-1:0]   pair_wdata;
    logic               pair_we;
    logic [PAIR_AW-1:0] pa_reg;

    logic [CNT_W-1:0]   ci_reg [NUM_SYMBOLS];
    logic [CNT_W-1:0]   cj_reg [NUM_SYMBOLS];

    logic [7:0]         ca_reg;
    logic [7:0]         cb_reg;
    logic [CNT_W-1:0]   row_reg;
    logic [PAIR_AW-1:0] clr_reg;
    logic [SYM_W-1:0]   s_reg;
    logic [SYM_W-1:0]   t_reg;
    logic [CNT_W-1:0]   c_reg;
    logic [OP_W-1:0]    exp_reg;
    logic [OP_W-1:0]    obs_reg;
    logic [OP_W-1:0]    d_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [SCORE_W-1:0] sum_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               status_reg;

    logic [OP_W-1:0]    mul_a;
    logic [OP_W-1:0]    mul_b;
    logic [2*OP_W-1:0]  mul_p;

    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [SCORE_W:0]   sum_wide;

    logic               accept;
    logic               bad_col;
    logic               both_sym;
    logic               last_cell;

    assign accept = start && (state_reg == ST_IDLE);

    // Clamp configured sizes to capacity
    assign n_eff = (int'(num_seqs_reg) > MAX_SEQS) ? CNT_W'(MAX_SEQS) : num_seqs_reg;
    assign l_eff = (int'(num_cols_reg) > MAX_COLS) ? CNT_W'(MAX_COLS) : num_cols_reg;

    assign bad_col   = ({1'b0, col_a} >= l_eff) || ({1'b0, col_b} >= l_eff);
    assign both_sym  = (sym_a_reg < NO_SYMBOL) && (sym_b_reg < NO_SYMBOL);
    assign last_cell = (s_reg == LAST_SYM) && (t_reg == LAST_SYM);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_seqs_reg <= CNT_W'(256);
            num_cols_reg <= CNT_W'(256);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NUM_SEQS: num_seqs_reg <= wr_data;
                REG_NUM_COLS: num_cols_reg <= wr_data;
                default:      ;
            endcase
        end
    end

    // Residue store: one write port for loads, two registered read ports
    assign ld_en     = accept && (cmd == CMD_LOAD) && (int'(seq_index) < MAX_SEQS)
                       && (int'(col_a) < MAX_COLS);
    assign ld_addr   = AW'(seq_index) * AW'(MAX_COLS) + AW'(col_a);
    assign rd_addr_a = AW'(row_reg) * AW'(MAX_COLS) + AW'(ca_reg);
    assign rd_addr_b = AW'(row_reg) * AW'(MAX_COLS) + AW'(cb_reg);

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            store_mem[ld_addr] <= encode_byte(residue);
        end
        sym_a_reg <= store_mem[rd_addr_a];
        sym_b_reg <= store_mem[rd_addr_b];
    end

    // Joint count memory
    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_waddr] <= pair_wdata;
        end
        pair_q_reg <= pair_mem[pair_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_reg == PAIR_AW'(PAIR_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start && (cmd == CMD_QUERY))
                begin
                    state_next = (bad_col || (col_a == col_b)) ? ST_DONE : ST_CNT_RD;
                end
            end
            ST_CNT_RD:   state_next = (row_reg == n_eff) ? ST_SC_RD : ST_CNT_PAIR;
            ST_CNT_PAIR: state_next = both_sym ? ST_CNT_WR : ST_CNT_RD;
            ST_CNT_WR:   state_next = ST_CNT_RD;
            ST_SC_RD:    state_next = ST_SC_CHK;
            ST_SC_CHK:   state_next = (pair_q_reg == '0) ? ST_SC_NEXT : ST_SC_M1;
            ST_SC_M1:    state_next = ST_SC_M2;
            ST_SC_M2:    state_next = ST_SC_M3;
            ST_SC_M3:    state_next = ST_SC_M4;
            ST_SC_M4:    state_next = ST_SC_DS;
            ST_SC_DS:    state_next = ST_SC_DIV;
            ST_SC_DIV:   if (div_done) state_next = ST_SC_ADD;
            ST_SC_ADD:   state_next = ST_SC_NEXT;
            ST_SC_NEXT:  state_next = last_cell ? ST_DONE : ST_SC_RD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs and shared multiplier operand select
    always_comb
    begin
        pair_we    = 1'b0;
        pair_waddr = pa_reg;
        pair_wdata = '0;
        pair_raddr = pair_addr(s_reg, t_reg);
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                pair_we    = 1'b1;
                pair_waddr = clr_reg;
            end
            ST_CNT_PAIR: pair_raddr = pair_addr(sym_a_reg, sym_b_reg);
            ST_CNT_WR:
            begin
                pair_we    = 1'b1;
                pair_wdata = pair_q_reg + 1'b1;
            end
            ST_SC_CHK:
            begin
                pair_we    = 1'b1;
                pair_waddr = pair_addr(s_reg, t_reg);
            end
            ST_SC_M1:
            begin
                mul_a = OP_W'(ci_reg[s_reg]);
                mul_b = OP_W'(cj_reg[t_reg]);
            end
            ST_SC_M2:
            begin
                mul_a = OP_W'(c_reg);
                mul_b = OP_W'(n_eff);
            end
            ST_SC_M3:
            begin
                mul_a = OP_W'(n_eff);
                mul_b = exp_reg;
            end
            ST_SC_M4:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            ST_SC_DS:    div_start = 1'b1;
            default:     ;
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign busy     = (state_reg != ST_IDLE);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, div_quo[SCORE_W-1:0]};

    cpos_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_reg, {FRAC_W{1'b0}}}),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            for (int k = 0; k < NUM_SYMBOLS; k++)
            begin
                ci_reg[k] <= '0;
                cj_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            // Clear the marginal counts at query start, bump them per row
            if (accept && (cmd == CMD_QUERY))
            begin
                for (int k = 0; k < NUM_SYMBOLS; k++)
                begin
                    ci_reg[k] <= '0;
                    cj_reg[k] <= '0;
                end
            end
            else if (state_reg == ST_CNT_PAIR)
            begin
                if (sym_a_reg < NO_SYMBOL)
                begin
                    ci_reg[sym_a_reg] <= ci_reg[sym_a_reg] + 1'b1;
                end
                if (sym_b_reg < NO_SYMBOL)
                begin
                    cj_reg[sym_b_reg] <= cj_reg[sym_b_reg] + 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ca_reg     <= col_a;
                cb_reg     <= col_b;
                row_reg    <= '0;
                s_reg      <= '0;
                t_reg      <= '0;
                sum_reg    <= '0;
                score_reg  <= '0;
                status_reg <= bad_col ? STATUS_BAD_COL : STATUS_OK;
            end
            ST_CNT_PAIR:
            begin
                pa_reg <= pair_addr(sym_a_reg, sym_b_reg);
                if (!both_sym)
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            ST_CNT_WR:   row_reg <= row_reg + 1'b1;
            ST_SC_CHK:   c_reg   <= pair_q_reg;
            ST_SC_M1:    exp_reg <= OP_W'(mul_p);
            ST_SC_M2:    obs_reg <= OP_W'(mul_p);
            ST_SC_M3:
            begin
                den_reg <= DEN_W'(mul_p);
                d_reg   <= (obs_reg >= exp_reg) ? obs_reg - exp_reg : exp_reg - obs_reg;
            end
            ST_SC_M4:    num_reg <= NUM_W'(mul_p);
            ST_SC_ADD:
            begin
                // Saturate the running sum
                if ((div_quo[QUO_W-1:SCORE_W] != '0) || sum_wide[SCORE_W])
                begin
                    sum_reg <= SCORE_MAX;
                end
                else
                begin
                    sum_reg <= sum_wide[SCORE_W-1:0];
                end
            end
            ST_SC_NEXT:
            begin
                if (t_reg == LAST_SYM)
                begin
                    t_reg <= '0;
                    s_reg <= s_reg + 1'b1;
                end
                else
                begin
                    t_reg <= t_reg + 1'b1;
                end
                if (last_cell)
                begin
                    score_reg <= sum_reg;
                end
            end
            default: ;
        endcase
    end

    assign done   = (state_reg == ST_DONE);
    assign score  = score_reg;
    assign status = status_reg;

    // An accepted query raises busy on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    // A load never produces a result strobe
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_LOAD)) |=> !done)
        else $error("load produced a result");

    // A bad column reports a zero score
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_BAD_COL)) |-> (score == '0))
        else $error("bad column with nonzero score");

    // Divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_SC_DIV))
        else $error("divider done outside wait state");

endmodule

// File: tb/sv/column_pair_omes_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_pair_omes_score_checker
// Watches the command, register and result channels of the column pair
// score block, keeps its own copy of the alignment and the registers,
// predicts each query's score and status, and counts mismatches.
// ----------------------------------------------------------------------------
module column_pair_omes_score_checker
    import cpos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cmd,
    input  logic [7:0]         seq_index,
    input  logic [7:0]         col_a,
    input  logic [7:0]         col_b,
    input  logic [7:0]         residue,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [CNT_W-1:0]   wr_data,
    input  logic               done,
    input  logic [SCORE_W-1:0] score,
    input  logic               status,
    output int                 errors,
    output int                 pending
);

    localparam int ROWS = 256;
    localparam int COLS = 256;
    localparam string ALPHABET = "-ACDEFGHIKLMNPQRSTVWY";

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               status;
    } omes_result_t;

    logic [SYM_W-1:0] alignment [ROWS*COLS];
    logic [CNT_W-1:0] rows_in_use;
    logic [CNT_W-1:0] cols_in_use;
    omes_result_t     expected_scores [$];

    // Map a residue byte to its symbol code; unknown bytes get no symbol
    function automatic logic [SYM_W-1:0] symbol_of(input logic [7:0] b);
        for (int s = 0; s < NUM_SYMBOLS; s++)
            if (ALPHABET[s] == b)
                return SYM_W'(s);
        return NO_SYMBOL;
    endfunction

    // OMES sum over filled joint cells, each term floored to 16 fraction bits
    function automatic logic [SCORE_W-1:0] omes_of(input int ca, input int cb,
                                                   input int n);
        longint unsigned ci [NUM_SYMBOLS];
        longint unsigned cj [NUM_SYMBOLS];
        longint unsigned joint [NUM_SYMBOLS*NUM_SYMBOLS];
        longint unsigned sum, c, ex, ob, d, den, term;
        int x, y;
        sum = 0;
        foreach (ci[i]) ci[i] = 0;
        foreach (cj[i]) cj[i] = 0;
        foreach (joint[i]) joint[i] = 0;
        for (int r = 0; r < n; r++)
        begin
            x = alignment[r*COLS + ca];
            y = alignment[r*COLS + cb];
            if (x < NUM_SYMBOLS) ci[x]++;
            if (y < NUM_SYMBOLS) cj[y]++;
            if (x < NUM_SYMBOLS && y < NUM_SYMBOLS) joint[x*NUM_SYMBOLS + y]++;
        end
        for (int s = 0; s < NUM_SYMBOLS; s++)
            for (int t = 0; t < NUM_SYMBOLS; t++)
            begin
                c = joint[s*NUM_SYMBOLS + t];
                if (c != 0)
                begin
                    ex   = ci[s] * cj[t];
                    ob   = c * n;
                    d    = (ob >= ex) ? ob - ex : ex - ob;
                    den  = longint'(n) * ex;
                    term = ((d*d / den) << FRAC_W) + (((d*d % den) << FRAC_W) / den);
                    if (term > SCORE_MAX || sum > SCORE_MAX - term)
                        sum = SCORE_MAX;
                    else
                        sum += term;
                end
            end
        return sum[SCORE_W-1:0];
    endfunction

    initial
    begin
        foreach (alignment[i]) alignment[i] = '0;
    end

    assign pending = expected_scores.size();

    always @(posedge clk or negedge rst_n)
    begin
        omes_result_t exp_r;
        int n, l;
        if (!rst_n)
        begin
            rows_in_use <= 9'd256;
            cols_in_use <= 9'd256;
            errors      <= 0;
        end
        else
        begin
            // track register writes
            if (wr_en)
            begin
                if (wr_index == REG_NUM_SEQS) rows_in_use <= wr_data;
                else                          cols_in_use <= wr_data;
            end

            // predict on each accepted command transfer
            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                    alignment[int'(seq_index)*COLS + int'(col_a)] = symbol_of(residue);
                else
                begin
                    n = (rows_in_use > ROWS) ? ROWS : rows_in_use;
                    l = (cols_in_use > COLS) ? COLS : cols_in_use;
                    if (col_a >= l || col_b >= l)
                    begin
                        exp_r.score  = '0;
                        exp_r.status = STATUS_BAD_COL;
                    end
                    else
                    begin
                        exp_r.status = STATUS_OK;
                        exp_r.score  = (col_a == col_b) ? '0 : omes_of(col_a, col_b, n);
                    end
                    expected_scores.push_back(exp_r);
                end
            end

            // compare each result transfer with the oldest prediction
            if (done)
            begin
                if (expected_scores.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result score=%h status=%0d", score, status);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_scores.pop_front();
                    if (score !== exp_r.score || status !== exp_r.status)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected score=%h status=%0d, got score=%h status=%0d",
                                     exp_r.score, exp_r.status, score, status);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/column_pair_omes_score_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_pair_omes_score_tb
// Loads alignment columns and issues pair queries against the column pair
// score block across several register settings and sender idle rates; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module column_pair_omes_score_tb;
    import cpos_pkg::*;

    localparam string ALPHABET = "-ACDEFGHIKLMNPQRSTVWY";

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cmd = CMD_LOAD;
    logic [7:0]         seq_index = '0;
    logic [7:0]         col_a = '0;
    logic [7:0]         col_b = '0;
    logic [7:0]         residue = '0;
    logic               wr_en = 1'b0;
    logic               wr_index = REG_NUM_SEQS;
    logic [CNT_W-1:0]   wr_data = '0;
    logic               done;
    logic [SCORE_W-1:0] score;
    logic               status;
    int                 errors;
    int                 pending;

    int idle_pct = 0;
    int items_sent = 0;
    int rows_cfg = 256;
    int cols_cfg = 256;

    // Store entries that have been loaded at least once
    bit filled [256*256];

    always #5 clk = ~clk;

    column_pair_omes_score dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .seq_index(seq_index), .col_a(col_a), .col_b(col_b), .residue(residue),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .score(score), .status(status)
    );

    column_pair_omes_score_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .seq_index(seq_index), .col_a(col_a), .col_b(col_b), .residue(residue),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .score(score), .status(status),
        .errors(errors), .pending(pending)
    );

    // Transfer one command; insert random idle cycles first
    task automatic issue(input logic c, input int r, input int a, input int b,
                         input int byte_val);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        cmd       = c;
        seq_index = 8'(r);
        col_a     = 8'(a);
        col_b     = 8'(b);
        residue   = 8'(byte_val);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (c == CMD_LOAD)
            filled[{8'(r), 8'(a)}] = 1'b1;
        items_sent++;
    endtask

    // A query may only read loaded entries over the rows in use
    function automatic bit query_safe(input int a, input int b);
        int n, lim;
        n   = (rows_cfg > 256) ? 256 : rows_cfg;
        lim = (cols_cfg > 256) ? 256 : cols_cfg;
        if (a >= lim || b >= lim || a == b)
            return 1'b1;
        for (int r = 0; r < n; r++)
            if (!filled[r*256 + a] || !filled[r*256 + b])
                return 1'b0;
        return 1'b1;
    endfunction

    // Mostly alignment symbols, some from a narrow set, some arbitrary bytes
    function automatic int pick_residue();
        int p;
        p = $urandom_range(99);
        if (p < 40) return ALPHABET[$urandom_range(2)];
        if (p < 80) return ALPHABET[$urandom_range(20)];
        return $urandom_range(255);
    endfunction

    // Drain results, then write one register
    task automatic write_reg(input logic idx, input int val);
        start = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = CNT_W'(val);
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == REG_NUM_SEQS) rows_cfg = val; else cols_cfg = val;
    endtask

    // Fill both columns over the rows in use, then query the pair
    task automatic pair_query(input int a, input int b);
        int n;
        n = (rows_cfg > 256) ? 256 : rows_cfg;
        for (int r = 0; r < n; r++)
        begin
            issue(CMD_LOAD, r, a, $urandom_range(255), pick_residue());
            if (b != a)
                issue(CMD_LOAD, r, b, $urandom_range(255), pick_residue());
        end
        issue(CMD_QUERY, $urandom_range(255), a, b, $urandom_range(255));
    endtask

    task automatic run_phase(input int n, input int l, input int pct, input int budget);
        int stop_at, p, lim, qa, qb;
        write_reg(REG_NUM_SEQS, n);
        write_reg(REG_NUM_COLS, l);
        idle_pct = pct;
        lim = (l > 256) ? 256 : l;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            p = $urandom_range(99);
            if (p < 65 && lim >= 1)
                pair_query($urandom_range(lim-1), $urandom_range(lim-1));
            else if (p < 75 && lim >= 1)
            begin
                qa = $urandom_range(lim-1);
                qb = 0;
                if (!query_safe(qa, qb))
                    qb = qa;
                issue(CMD_QUERY, $urandom_range(255), qa, qb, 0);
            end
            else if (p < 90)
            begin
                qa = $urandom_range(255);
                qb = $urandom_range(255);
                if (!query_safe(qa, qb))
                    qb = qa;
                issue(CMD_QUERY, $urandom_range(255), qa, qb, $urandom_range(255));
            end
            else
                issue(CMD_LOAD, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
        end
    endtask

    // Safety net against a hung run
    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: edge symbols, foreign bytes, same column, bad columns
        write_reg(REG_NUM_SEQS, 4);
        write_reg(REG_NUM_COLS, 8);
        for (int r = 0; r < 4; r++)
        begin
            issue(CMD_LOAD, r, 0, 0, (r < 2) ? "-" : "Y");
            issue(CMD_LOAD, r, 1, 0, (r < 2) ? "A" : "W");
            issue(CMD_LOAD, r, 2, 0, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : "C");
        end
        issue(CMD_QUERY, 0, 0, 1, 0);
        issue(CMD_QUERY, 0, 1, 0, 0);
        issue(CMD_QUERY, 0, 0, 2, 0);
        issue(CMD_QUERY, 0, 2, 2, 0);
        issue(CMD_QUERY, 0, 0, 8, 0);
        issue(CMD_QUERY, 0, 255, 0, 0);
        issue(CMD_QUERY, 255, 255, 255, 255);
        issue(CMD_LOAD, 255, 255, 255, "a");

        // random phases over register settings and idle rates
        run_phase(5, 8, 0, 40);
        run_phase(16, 40, 88, 40);
        run_phase(1, 256, 13, 25);
        run_phase(12, 256, 0, 30);
        run_phase(0, 3, 88, 12);
        run_phase(3, 0, 13, 10);
        run_phase(3, 1, 0, 10);
        run_phase(9, 511, 13, 30);

        // full height with the row count clamped to capacity
        write_reg(REG_NUM_SEQS, 300);
        write_reg(REG_NUM_COLS, 20);
        idle_pct = 13;
        pair_query(3, 17);
        issue(CMD_QUERY, 0, 17, 3, 0);
        issue(CMD_QUERY, 0, 3, 20, 0);

        // drain and settle
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
sv/cpos_pkg.sv
sv/cpos_divider.sv
sv/column_pair_omes_score.sv
tb/sv/column_pair_omes_score_checker.sv
tb/sv/column_pair_omes_score_tb.sv
